// File: sv/assert_macros.svh
// Assertion macros for the pulse encoder RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while reset is asserted
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked property that must also hold during reset
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: sv/rlspe_pkg.sv
// Types, constants and helper functions for the RGB LED pulse encoder.
// No dependencies; imported by every module of the block.
package rlspe_pkg;

    localparam int CHAN_W          = 8;
    localparam int PIXEL_BYTES     = 9;
    localparam int FRAME_W         = PIXEL_BYTES * 8;
    localparam int RESET_BYTES_DEF = 15;
    localparam logic [CHAN_W-1:0] BRIGHT_RST = 8'hFF;

    // Line code for one data bit, sent msb first
    localparam logic [2:0] PULSE_ONE  = 3'b110;
    localparam logic [2:0] PULSE_ZERO = 3'b100;

    typedef struct packed {
        logic              last;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
    } t_pixel;

    // Encoded pixel handed to the serializer
    typedef struct packed {
        logic               last;
        logic [FRAME_W-1:0] pulses;
    } t_frame;

    // (c * b) >> 8
    function automatic logic [CHAN_W-1:0] scale_chan(input logic [CHAN_W-1:0] c,
                                                    input logic [CHAN_W-1:0] b);
        logic [2*CHAN_W-1:0] prod;
        prod = c * b;
        return prod[2*CHAN_W-1:CHAN_W];
    endfunction

    // Each bit becomes a three-bit pulse, msb first
    function automatic logic [3*CHAN_W-1:0] pulse_expand(input logic [CHAN_W-1:0] v);
        logic [3*CHAN_W-1:0] acc;
        acc = '0;
        for (int k = 0; k < CHAN_W; k++) begin
            acc[3*k +: 3] = v[k] ? PULSE_ONE : PULSE_ZERO;
        end
        return acc;
    endfunction

endpackage

// File: sv/rlspe_scale.sv
// Input register, brightness register, channel scaling and pulse expansion.
// Depends on rlspe_pkg.
module rlspe_scale
    import rlspe_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wen,
    input  logic [CHAN_W-1:0]    i_cfg_wdata,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [3*CHAN_W-1:0]  s_axis_tdata,   // red, green, blue
    input  logic                 s_axis_tlast,   // last_pixel
    output logic                 o_frame_valid,
    input  logic                 i_frame_ready,
    output t_frame               o_frame
);

    logic              r_pix_valid;
    t_pixel            r_pix;
    logic [CHAN_W-1:0] r_bright;
    logic              pix_take;

    // Input register frees up as soon as the serializer takes the frame
    assign s_axis_tready = !r_pix_valid || i_frame_ready;
    assign pix_take      = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pix_valid <= 1'b0;
            r_bright    <= BRIGHT_RST;
        end else begin
            if (pix_take) begin
                r_pix_valid <= 1'b1;
            end else if (i_frame_ready) begin
                r_pix_valid <= 1'b0;
            end
            if (i_cfg_wen) begin
                r_bright <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pix_take) begin
            r_pix.red   <= s_axis_tdata[CHAN_W-1:0];
            r_pix.green <= s_axis_tdata[2*CHAN_W-1:CHAN_W];
            r_pix.blue  <= s_axis_tdata[3*CHAN_W-1:2*CHAN_W];
            r_pix.last  <= s_axis_tlast;
        end
    end

    // Scale and expand, green then red then blue from the top
    assign o_frame_valid = r_pix_valid;
    always_comb begin
        o_frame.last   = r_pix.last;
        o_frame.pulses = {pulse_expand(scale_chan(r_pix.green, r_bright)),
                          pulse_expand(scale_chan(r_pix.red,   r_bright)),
                          pulse_expand(scale_chan(r_pix.blue,  r_bright))};
    end

endmodule

// File: sv/rlspe_serial.sv
// Frame shift register and byte output register; appends the reset frame.
// Depends on rlspe_pkg and assert_macros.svh.
`include "assert_macros.svh"
module rlspe_serial
    import rlspe_pkg::*;
#(
    parameter int RESET_BYTES = RESET_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_frame_valid,
    output logic        o_frame_ready,
    input  t_frame      i_frame,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // spi_byte
    output logic        m_axis_tlast    // run_end
);

    localparam int CNT_W = $clog2(PIXEL_BYTES + RESET_BYTES);
    localparam logic [CNT_W-1:0] LAST_PIX = CNT_W'(PIXEL_BYTES - 1);
    localparam logic [CNT_W-1:0] LAST_ALL = CNT_W'(PIXEL_BYTES + RESET_BYTES - 1);

    logic               r_busy;
    logic               r_last;
    logic [CNT_W-1:0]   r_cnt;
    logic [FRAME_W-1:0] r_enc;
    logic               r_ovalid;
    logic [7:0]         r_odata;
    logic               r_olast;

    logic [CNT_W-1:0]   last_idx;
    logic               final_beat;
    logic               adv;
    logic               load;

    assign last_idx      = r_last ? LAST_ALL : LAST_PIX;
    assign final_beat    = (r_cnt == last_idx);
    assign adv           = r_busy && (!r_ovalid || m_axis_tready);
    assign o_frame_ready = !r_busy || (adv && final_beat);
    assign load          = i_frame_valid && o_frame_ready;

    // Control: frame busy flag, byte counter, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (adv) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            if (load) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (adv) begin
                r_busy <= !final_beat;
                r_cnt  <= r_cnt + 1'b1;
            end
        end
    end

    // Payload: shifting zeros in makes the reset-frame bytes for free
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_odata <= r_enc[FRAME_W-1 -: 8];
            r_olast <= final_beat;
        end
        if (load) begin
            r_enc  <= i_frame.pulses;
            r_last <= i_frame.last;
        end else if (adv) begin
            r_enc  <= {r_enc[FRAME_W-9:0], 8'h00};
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tlast  = r_olast;

    `ASSERT_CLK(a_cnt_range, i_clk, i_rst_n, r_busy |-> (r_cnt <= last_idx), "byte count past end of run")
    `ASSERT_CLK(a_rst_zero, i_clk, i_rst_n, (r_busy && (r_cnt >= CNT_W'(PIXEL_BYTES))) |-> (r_enc == '0), "reset frame byte not zero")
    `ASSERT_CLK(a_run_done, i_clk, i_rst_n, (adv && final_beat && !load) |=> (!r_busy && r_ovalid && r_olast), "run end not flagged on final beat")
    `ASSERT_ALWAYS(a_rst_idle, i_clk, !i_rst_n |=> (!r_busy && !r_ovalid), "not idle after reset")

endmodule

// File: sv/rgb_led_spi_pulse_encoder_unit.sv
// Top level of the RGB LED pulse encoder: stream ports and parameter plumbing.
// Depends on rlspe_pkg, rlspe_scale and rlspe_serial.
//
// Takes one pixel per beat (red, green, blue bytes), scales each channel by the
// brightness register as (c * brightness) >> 8, and emits the green, red, blue
// bits as 3-bit line pulses (110 = one, 100 = zero) packed into nine bytes, most
// significant first, one byte per cycle while the output is ready. A pixel
// flagged with tlast is followed by RESET_BYTES zero bytes. tlast on the output
// marks the final byte of each pixel's run. Throughput is set by the single
// byte-wide output register; the first byte passes the input register, the
// frame shift register and the byte output register. Two pixels can be buffered
// ahead of the output. Write brightness (reset value 255) only while idle.
module rgb_led_spi_pulse_encoder_unit
    import rlspe_pkg::*;
#(
    parameter int RESET_BYTES = RESET_BYTES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wen,
    input  logic [CHAN_W-1:0]    i_cfg_wdata,    // brightness
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [3*CHAN_W-1:0]  s_axis_tdata,   // red, green, blue
    input  logic                 s_axis_tlast,   // last_pixel
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [7:0]           m_axis_tdata,   // spi_byte
    output logic                 m_axis_tlast    // run_end
);

    logic   frame_valid;
    logic   frame_ready;
    t_frame frame;

    // Scaling and pulse expansion
    rlspe_scale u_scale (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wen     (i_cfg_wen),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .o_frame_valid (frame_valid),
        .i_frame_ready (frame_ready),
        .o_frame       (frame)
    );

    // Byte serializer with reset frame
    rlspe_serial #(
        .RESET_BYTES (RESET_BYTES)
    ) u_serial (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_frame_valid (frame_valid),
        .o_frame_ready (frame_ready),
        .i_frame       (frame),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

// File: tb/sv/rlspe_stream_checker.sv
// Stream checker for the RGB LED pulse encoder: predicts and compares output beats.
// Depends on rlspe_pkg; instantiated by tb beside the encoder.
module rlspe_stream_checker
    import rlspe_pkg::*;
#(
    parameter int RESET_BYTES = RESET_BYTES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wen,
    input  logic [CHAN_W-1:0]   i_cfg_wdata,
    input  logic                i_pix_valid,
    input  logic                i_pix_ready,
    input  logic [3*CHAN_W-1:0] i_pix_data,     // red, green, blue
    input  logic                i_pix_last,
    input  logic                i_spi_valid,
    input  logic                i_spi_ready,
    input  logic [7:0]          i_spi_data,
    input  logic                i_spi_last,
    output int                  o_fail_count,
    output int                  o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SHOW_LIMIT = 10;

    typedef struct packed {
        logic [7:0] spi_byte;
        logic       run_end;
    } t_spi_beat;

    t_spi_beat         spi_beat_q[$];
    logic [CHAN_W-1:0] brightness;
    int                fails = 0;

    // Channel after the global dimming: upper byte of the product
    function automatic logic [CHAN_W-1:0] dim(input logic [CHAN_W-1:0] chan,
                                              input logic [CHAN_W-1:0] level);
        logic [2*CHAN_W-1:0] prod;
        prod = chan * level;
        return prod[2*CHAN_W-1:CHAN_W];
    endfunction

    // Line code of one channel, msb of the channel in the top pulse
    function automatic logic [3*CHAN_W-1:0] line_code(input logic [CHAN_W-1:0] v);
        logic [3*CHAN_W-1:0] code;
        code = '0;
        for (int k = CHAN_W - 1; k >= 0; k--) begin
            code = {code[3*CHAN_W-4:0], v[k] ? PULSE_ONE : PULSE_ZERO};
        end
        return code;
    endfunction

    always @(posedge i_clk) begin
        t_pixel              px;
        logic [CHAN_W-1:0]   chans [3];
        logic [3*CHAN_W-1:0] code;
        t_spi_beat           next_beat;
        t_spi_beat           want;
        t_spi_beat           got;

        if (!i_rst_n) begin
            brightness = BRIGHT_RST;
            spi_beat_q.delete();
        end else begin
            if (i_cfg_wen) begin
                brightness = i_cfg_wdata;
            end

            // Output beat against the oldest prediction
            if (i_spi_valid && i_spi_ready) begin
                got.spi_byte = i_spi_data;
                got.run_end  = i_spi_last;
                if (spi_beat_q.size() == 0) begin
                    fails++;
                    if (fails <= SHOW_LIMIT) begin
                        $display("%0t: unexpected beat byte %02h end %0b",
                                 $realtime, got.spi_byte, got.run_end);
                    end
                end else begin
                    want = spi_beat_q.pop_front();
                    if (want.spi_byte !== got.spi_byte || want.run_end !== got.run_end) begin
                        fails++;
                        if (fails <= SHOW_LIMIT) begin
                            $display("%0t: beat mismatch, expected byte %02h end %0b, %s",
                                     $realtime, want.spi_byte, want.run_end,
                                     $sformatf("got byte %02h end %0b",
                                               got.spi_byte, got.run_end));
                        end
                    end
                end
            end

            // Accepted pixel: green, red, blue, then the latch frame if last
            if (i_pix_valid && i_pix_ready) begin
                px       = t_pixel'({i_pix_last, i_pix_data});
                chans[0] = dim(px.green, brightness);
                chans[1] = dim(px.red, brightness);
                chans[2] = dim(px.blue, brightness);
                for (int c = 0; c < 3; c++) begin
                    code = line_code(chans[c]);
                    for (int b = 2; b >= 0; b--) begin
                        next_beat.spi_byte = code[8*b +: 8];
                        next_beat.run_end  = !px.last && c == 2 && b == 0;
                        spi_beat_q.push_back(next_beat);
                    end
                end
                if (px.last) begin
                    for (int n = 0; n < RESET_BYTES; n++) begin
                        next_beat.spi_byte = 8'h00;
                        next_beat.run_end  = (n == RESET_BYTES - 1);
                        spi_beat_q.push_back(next_beat);
                    end
                end
            end
        end
        o_pending    <= spi_beat_q.size();
        o_fail_count <= fails;
    end

endmodule

// File: tb/sv/tb.sv
// Testbench top for the RGB LED pulse encoder: clock, reset, stimulus and verdict.
// Depends on rlspe_pkg, rgb_led_spi_pulse_encoder_unit and rlspe_stream_checker.
module tb
    import rlspe_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RESET_BYTES = RESET_BYTES_DEF;
    localparam int STALL_LIMIT = 2000;
    localparam int IDLE_PCT    = 38;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_wen;
    logic [CHAN_W-1:0]   i_cfg_wdata;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [3*CHAN_W-1:0] s_axis_tdata;
    logic                s_axis_tlast;
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [7:0]          m_axis_tdata;
    logic                m_axis_tlast;

    logic steady = 1'b0;
    int   fail_count;
    int   pending;
    int   idle_cycles = 0;
    int   n_beats     = 0;
    int   n_pixels    = 0;
    int   n_strips    = 0;
    int   n_settings  = 0;

    rgb_led_spi_pulse_encoder_unit #(
        .RESET_BYTES (RESET_BYTES)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wen     (i_cfg_wen),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    rlspe_stream_checker #(
        .RESET_BYTES (RESET_BYTES)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wen    (i_cfg_wen),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_pix_valid  (s_axis_tvalid),
        .i_pix_ready  (s_axis_tready),
        .i_pix_data   (s_axis_tdata),
        .i_pix_last   (s_axis_tlast),
        .i_spi_valid  (m_axis_tvalid),
        .i_spi_ready  (m_axis_tready),
        .i_spi_data   (m_axis_tdata),
        .i_spi_last   (m_axis_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Activity monitor for the stall watchdog
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            n_beats <= n_beats + 1;
        end
    end

    initial begin
        while (idle_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("stall: no beat moved for %0d cycles", STALL_LIMIT);
        $display("simulation failed");
        $finish;
    end

    // Output side back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Extremes for 30 percent of picks, so saturation and all-zero codes show up often
    function automatic logic [CHAN_W-1:0] rand_chan();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
            return '0;
        end else if (pick < 30) begin
            return '1;
        end
        return CHAN_W'($urandom_range(0, 255));
    endfunction

    task automatic send_pixel(input logic [CHAN_W-1:0] red, input logic [CHAN_W-1:0] green,
                              input logic [CHAN_W-1:0] blue, input logic last);
        if (!steady) begin
            while ($urandom_range(0, 99) < IDLE_PCT) begin
                s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {blue, green, red};
        s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        n_pixels++;
        if (last) begin
            n_strips++;
        end
    endtask

    // Hold off the sender until every predicted beat has come out
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_brightness(input logic [CHAN_W-1:0] level);
        wait_drained();
        i_cfg_wen   <= 1'b1;
        i_cfg_wdata <= level;
        @(posedge i_clk);
        i_cfg_wen   <= 1'b0;
        n_settings++;
    endtask

    // Whole strips of random length, with an occasional full drain between them
    task automatic random_phase(input int n_items);
        int target;
        int len;
        target = n_pixels + n_items;
        while (n_pixels < target) begin
            len = ($urandom_range(0, 4) == 0) ? 1 : $urandom_range(2, 12);
            for (int p = 0; p < len; p++) begin
                send_pixel(rand_chan(), rand_chan(), rand_chan(), p == len - 1);
            end
            if ($urandom_range(0, 5) == 0) begin
                wait_drained();
            end
        end
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        i_cfg_wen     <= 1'b0;
        i_cfg_wdata   <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed pixels at the reset brightness
        send_pixel(8'h00, 8'h00, 8'h00, 1'b0);
        send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
        send_pixel(8'hFF, 8'h00, 8'h00, 1'b0);
        send_pixel(8'h00, 8'hFF, 8'h00, 1'b0);
        send_pixel(8'h00, 8'h00, 8'hFF, 1'b0);
        send_pixel(8'hAA, 8'h55, 8'h0F, 1'b0);
        send_pixel(8'h01, 8'h80, 8'h7E, 1'b1);
        send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1);
        send_pixel(8'h00, 8'h00, 8'h00, 1'b1);

        // Brightness zero blanks every channel
        set_brightness(8'h00);
        send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
        send_pixel(8'h5A, 8'hC3, 8'h81, 1'b1);

        // Lowest nonzero brightness still rounds everything down to zero
        set_brightness(8'h01);
        send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
        send_pixel(8'h01, 8'h80, 8'hFF, 1'b1);

        // Half brightness with both sides running flat out
        set_brightness(8'h80);
        steady <= 1'b1;
        random_phase(60);
        steady <= 1'b0;

        set_brightness(CHAN_W'($urandom_range(2, 254)));
        random_phase(80);

        set_brightness(8'hFF);
        random_phase(80);

        s_axis_tvalid <= 1'b0;
        s_axis_tlast  <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("sent %0d pixels in %0d strips, %0d output beats seen",
                 n_pixels, n_strips, n_beats);
        $display("brightness written %0d times, from 0 up to 255, random stalls on both sides",
                 n_settings);
        if (fail_count == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
